### sv/tmops_pkg.sv
// ----------------------------------------------------------------------------
// tmops_pkg
// Types, command codes, panel constants and font tables shared by the text
// mode page streamer.
// ----------------------------------------------------------------------------
package tmops_pkg;

  localparam int TEXT_ROWS_DEF    = 8;
  localparam int TEXT_COLUMNS_DEF = 21;
  localparam int PANEL_WIDTH_DEF  = 128;

  localparam int PANEL_PAGES = 8;
  localparam int CELL_W      = 6;
  localparam int GLYPH_W     = 5;
  localparam int SEQ_LEN     = 28;
  localparam int HDR_LEN     = 3;

  localparam logic [2:0] CMD_SET_CURSOR = 3'd0;
  localparam logic [2:0] CMD_PUT_CHAR   = 3'd1;
  localparam logic [2:0] CMD_CLEAR      = 3'd2;
  localparam logic [2:0] CMD_REFRESH    = 3'd3;
  localparam logic [2:0] CMD_INIT       = 3'd4;
  localparam logic [2:0] CMD_TICK       = 3'd5;

  localparam logic [7:0] PAGE_ADDR_CMD = 8'hB0;
  localparam logic [7:0] COL_LOW_CMD   = 8'h00;
  localparam logic [7:0] COL_HIGH_CMD  = 8'h10;
  localparam logic [7:0] SPACE_CHAR    = 8'h20;
  localparam logic [7:0] CASE_FOLD     = 8'h20;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] pixel_x;
    logic [3:0] text_row;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] out_byte;
    logic       end_of_stream;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic transfer_active;
    logic tick;
  } dp_status_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_INIT  = 3'b010,
    PH_PAGES = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } ctl_state_t;

  localparam logic [7:0] INIT_SEQ [SEQ_LEN] = '{
    8'hAE, 8'h20, 8'h00, 8'hB0, 8'hC8, 8'h00, 8'h10, 8'h40,
    8'h81, 8'hCF, 8'hA1, 8'hA6, 8'hA8, 8'h3F, 8'hA4, 8'hD3,
    8'h00, 8'hD5, 8'h80, 8'hD9, 8'hF1, 8'hDA, 8'h12, 8'hDB,
    8'h40, 8'h8D, 8'h14, 8'hAF
  };

  // Glyphs hold the leftmost column in the top byte.
  localparam logic [39:0] DIGIT_GLYPH [10] = '{
    40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46,
    40'h21_41_45_4B_31, 40'h18_14_12_7F_10, 40'h27_45_45_45_39,
    40'h3C_4A_49_49_30, 40'h01_71_09_05_03, 40'h36_49_49_49_36,
    40'h06_49_49_29_1E
  };

  localparam logic [39:0] LETTER_GLYPH [26] = '{
    40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
    40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01,
    40'h3E_41_49_49_7A, 40'h7F_08_08_08_7F, 40'h00_41_7F_41_00,
    40'h20_40_41_3F_01, 40'h7F_08_14_22_41, 40'h7F_40_40_40_40,
    40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
    40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46,
    40'h46_49_49_49_31, 40'h01_01_7F_01_01, 40'h3F_40_40_40_3F,
    40'h1F_20_40_20_1F, 40'h7F_20_18_20_7F, 40'h63_14_08_14_63,
    40'h07_08_70_08_07, 40'h61_51_49_45_43
  };

  function automatic logic [39:0] glyph_bits(input logic [7:0] ch);
    logic [7:0]  up;
    logic [39:0] g;
    up = ch;
    if (ch >= 8'h61 && ch <= 8'h7A) begin
      up = ch - CASE_FOLD;
    end
    g = '0;
    if (up >= 8'h30 && up <= 8'h39) begin
      g = DIGIT_GLYPH[4'(up - 8'h30)];
    end else if (up >= 8'h41 && up <= 8'h5A) begin
      g = LETTER_GLYPH[5'(up - 8'h41)];
    end else begin
      case (up)
        8'h3A:   g = 40'h00_36_36_00_00;
        8'h2E:   g = 40'h00_60_60_00_00;
        8'h2F:   g = 40'h20_10_08_04_02;
        8'h25:   g = 40'h23_13_08_64_62;
        8'h2D:   g = 40'h08_08_08_08_08;
        default: g = '0;
      endcase
    end
    return g;
  endfunction

endpackage

### sv/tmops_ctrl.sv
// ----------------------------------------------------------------------------
// tmops_ctrl
// Handshake controller: takes requests, sequences the render step and owns
// the output valid flag.
// ----------------------------------------------------------------------------
module tmops_ctrl
  import tmops_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output ctl_cmd_t   ctl
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_stall   = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_free   = !out_valid_r || !out_stall;
  assign ctl.accept = in_valid && (state_r == ST_IDLE);
  assign ctl.load_out = (state_r == ST_EMIT) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (ctl.accept && status.transfer_active && status.tick) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### sv/tmops_datapath.sv
// ----------------------------------------------------------------------------
// tmops_datapath
// Character store, cursor, transfer counters and the byte renderer with its
// font lookup and output register.
// ----------------------------------------------------------------------------
module tmops_datapath
  import tmops_pkg::*;
#(
  parameter int TEXT_ROWS    = TEXT_ROWS_DEF,
  parameter int TEXT_COLUMNS = TEXT_COLUMNS_DEF,
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  input  in_item_t   in_data,
  input  ctl_cmd_t   ctl,
  output dp_status_t status,
  output out_item_t  out_data
);

  localparam int STORE_DEPTH = TEXT_ROWS * TEXT_COLUMNS;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LINE_BYTES  = HDR_LEN + PANEL_WIDTH;

  logic [7:0]             mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_r, vld_nxt;

  logic [6:0] x_off_r;
  logic [2:0] cur_row_r, cur_row_nxt;
  logic [4:0] cur_col_r, cur_col_nxt;
  logic       cur_en_r, cur_en_nxt;
  phase_t     phase_r, phase_nxt;
  logic [2:0] pg_r, pg_nxt;
  logic [7:0] bp_r, bp_nxt;
  logic [4:0] idx_r, idx_nxt;

  logic       e_is_data_r, e_eos_r, e_blank_r;
  logic [2:0] e_fc_r;
  logic [7:0] e_hdr_r;
  logic [7:0] rd_data_r;
  logic       rd_vld_r;
  out_item_t  out_data_r;

  logic              active, idle_cmd, tick_go, wr_en, clear_evt;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [15:0]       sc_prod;
  logic [5:0]        sc_col;
  logic [6:0]        pxl, dx;
  logic [14:0]       dprod;
  logic [4:0]        col;
  logic [2:0]        fc;
  logic [8:0]        cell_end;
  logic              blank;
  logic [7:0]        hdr_byte;
  logic [39:0]       glyph;
  logic [7:0]        glyph_col;

  assign active   = (phase_r != PH_IDLE);
  assign idle_cmd = ctl.accept && !active;
  assign tick_go  = ctl.accept && active && (in_data.cmd == CMD_TICK);
  assign status.transfer_active = active;
  assign status.tick            = (in_data.cmd == CMD_TICK);

  assign wr_en     = idle_cmd && (in_data.cmd == CMD_PUT_CHAR) && cur_en_r;
  assign clear_evt = idle_cmd && (in_data.cmd == CMD_CLEAR || in_data.cmd == CMD_INIT);
  assign wr_addr   = ADDR_W'(cur_row_r * TEXT_COLUMNS + cur_col_r);

  assign sc_prod = {8'd0, in_data.pixel_x} * 16'd171;
  assign sc_col  = 6'(sc_prod >> 10);

  assign pxl      = 7'(bp_r - 8'(HDR_LEN));
  assign dx       = pxl - x_off_r;
  assign dprod    = {8'd0, dx} * 15'd171;
  assign col      = 5'(dprod >> 10);
  assign fc       = 3'(dx - 7'({2'd0, col} * 7'd6));
  assign cell_end = 9'({4'd0, col} * 9'(CELL_W)) + {2'd0, x_off_r} + 9'(GLYPH_W);
  assign blank    = ({1'b0, pg_r} >= 4'(TEXT_ROWS)) || (pxl < x_off_r)
                 || (fc >= 3'(GLYPH_W)) || (col >= 5'(TEXT_COLUMNS))
                 || (cell_end > 9'(PANEL_WIDTH));
  assign rd_addr  = blank ? '0 : ADDR_W'(pg_r * TEXT_COLUMNS + col);

  always_comb begin
    case (bp_r)
      8'd0:    hdr_byte = PAGE_ADDR_CMD + {5'd0, pg_r};
      8'd1:    hdr_byte = COL_LOW_CMD;
      8'd2:    hdr_byte = COL_HIGH_CMD;
      default: hdr_byte = COL_LOW_CMD;
    endcase
  end

  always_comb begin
    vld_nxt = vld_r;
    if (clear_evt) begin
      vld_nxt = '0;
    end else if (wr_en) begin
      vld_nxt[wr_addr] = 1'b1;
    end
  end

  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    cur_en_nxt  = cur_en_r;
    phase_nxt   = phase_r;
    pg_nxt      = pg_r;
    bp_nxt      = bp_r;
    idx_nxt     = idx_r;
    if (tick_go) begin
      if (phase_r == PH_INIT) begin
        if (idx_r == 5'(SEQ_LEN - 1)) begin
          idx_nxt   = '0;
          phase_nxt = PH_PAGES;
          pg_nxt    = '0;
          bp_nxt    = '0;
        end else begin
          idx_nxt = idx_r + 5'd1;
        end
      end else begin
        if (bp_r == 8'(LINE_BYTES - 1)) begin
          bp_nxt = '0;
          if (pg_r == 3'(PANEL_PAGES - 1)) begin
            phase_nxt = PH_IDLE;
            pg_nxt    = '0;
          end else begin
            pg_nxt = pg_r + 3'd1;
          end
        end else begin
          bp_nxt = bp_r + 8'd1;
        end
      end
    end else if (idle_cmd) begin
      case (in_data.cmd)
        CMD_SET_CURSOR: begin
          if (in_data.text_row >= 4'(TEXT_ROWS) || sc_col >= 6'(TEXT_COLUMNS)) begin
            cur_en_nxt = 1'b0;
          end else begin
            cur_row_nxt = in_data.text_row[2:0];
            cur_col_nxt = sc_col[4:0];
            cur_en_nxt  = 1'b1;
          end
        end
        CMD_PUT_CHAR: begin
          if (cur_en_r) begin
            cur_col_nxt = cur_col_r + 5'd1;
            if (cur_col_r == 5'(TEXT_COLUMNS - 1)) begin
              cur_en_nxt = 1'b0;
            end
          end
        end
        CMD_REFRESH: begin
          phase_nxt = PH_PAGES;
          pg_nxt    = '0;
          bp_nxt    = '0;
        end
        CMD_INIT: begin
          phase_nxt = PH_INIT;
          idx_nxt   = '0;
          pg_nxt    = '0;
          bp_nxt    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      x_off_r   <= '0;
      cur_row_r <= '0;
      cur_col_r <= '0;
      cur_en_r  <= 1'b0;
      phase_r   <= PH_IDLE;
      pg_r      <= '0;
      bp_r      <= '0;
      idx_r     <= '0;
    end else begin
      vld_r     <= vld_nxt;
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      cur_en_r  <= cur_en_nxt;
      phase_r   <= phase_nxt;
      pg_r      <= pg_nxt;
      bp_r      <= bp_nxt;
      idx_r     <= idx_nxt;
      if (cfg_we) begin
        x_off_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data.char_code;
    end
    if (tick_go) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      rd_vld_r <= vld_r[rd_addr];
      e_fc_r   <= fc;
      if (phase_r == PH_INIT) begin
        e_is_data_r <= 1'b0;
        e_eos_r     <= 1'b0;
        e_blank_r   <= 1'b0;
        e_hdr_r     <= INIT_SEQ[idx_r];
      end else begin
        e_is_data_r <= (bp_r >= 8'(HDR_LEN));
        e_eos_r     <= (bp_r >= 8'(HDR_LEN)) && (pxl == 7'(PANEL_WIDTH - 1))
                    && (pg_r == 3'(PANEL_PAGES - 1));
        e_blank_r   <= blank;
        e_hdr_r     <= hdr_byte;
      end
    end
  end

  assign glyph     = glyph_bits(rd_vld_r ? rd_data_r : SPACE_CHAR);
  assign glyph_col = glyph[6'(8 * (3'd4 - e_fc_r)) +: 8];

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_data_r.is_data       <= e_is_data_r;
      out_data_r.end_of_stream <= e_eos_r;
      if (!e_is_data_r) begin
        out_data_r.out_byte <= e_hdr_r;
      end else if (e_blank_r) begin
        out_data_r.out_byte <= 8'd0;
      end else begin
        out_data_r.out_byte <= glyph_col;
      end
    end
  end

  assign out_data = out_data_r;

endmodule

### sv/text_mode_oled_page_streamer_unit.sv
// ----------------------------------------------------------------------------
// text_mode_oled_page_streamer_unit
// Text mode character generator that streams command and data bytes to a
// page organized monochrome panel.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_stall with an in_data struct and are taken
// at an edge where in_valid is high and in_stall is low. Set cursor, put
// char, clear, start refresh and start init produce nothing. While a
// transfer runs, only tick requests are acted on; each one yields one
// byte on out_valid/out_stall/out_data. A tick first reads the character
// store and computes the cell position; then, once the output is free, it
// does the font lookup and loads the output register. The next request is
// taken once that register is loaded, so while the receiver stalls one
// more tick is taken and then the block holds. x_offset is written through
// cfg_we/cfg_wdata while the block is idle; the user must keep to this, as
// the block itself does not enforce it. Synchronous reset empties the output,
// stops any transfer, disables the cursor and makes the whole character
// store read as spaces at once; clear and init do the same to the store.
// ----------------------------------------------------------------------------
module text_mode_oled_page_streamer_unit
  import tmops_pkg::*;
#(
  parameter int TEXT_ROWS    = TEXT_ROWS_DEF,
  parameter int TEXT_COLUMNS = TEXT_COLUMNS_DEF,
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  ctl_cmd_t   ctl;
  dp_status_t status;

  tmops_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .ctl       (ctl)
  );

  tmops_datapath #(
    .TEXT_ROWS    (TEXT_ROWS),
    .TEXT_COLUMNS (TEXT_COLUMNS),
    .PANEL_WIDTH  (PANEL_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .ctl       (ctl),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

### dv/text_mode_oled_page_streamer_unit_test.sv
// ----------------------------------------------------------------------------
// text_mode_oled_page_streamer_unit_test
// Self-checking testbench for the text mode page streamer. Requests edit the
// character store and start init or refresh transfers. Ticks then drain the
// panel byte stream. Each accepted request runs through a local model of the
// store, cursor and transfer counters. Every byte that model predicts is
// queued and compared field by field with the bytes the block delivers.
// Both handshakes idle and stall at random, and the x offset is moved
// between transfers.
// ----------------------------------------------------------------------------
module text_mode_oled_page_streamer_unit_test;
  import tmops_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS           = TEXT_ROWS_DEF;
  localparam int COLS           = TEXT_COLUMNS_DEF;
  localparam int PANEL_W        = PANEL_WIDTH_DEF;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  localparam logic [7:0] POWER_UP_BYTES [SEQ_LEN] = '{
    8'hAE, 8'h20, 8'h00, 8'hB0, 8'hC8, 8'h00, 8'h10, 8'h40,
    8'h81, 8'hCF, 8'hA1, 8'hA6, 8'hA8, 8'h3F, 8'hA4, 8'hD3,
    8'h00, 8'hD5, 8'h80, 8'hD9, 8'hF1, 8'hDA, 8'h12, 8'hDB,
    8'h40, 8'h8D, 8'h14, 8'hAF
  };

  // Five columns per glyph, leftmost column in the top byte.
  localparam logic [39:0] NUM_FONT [10] = '{
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E
  };

  localparam logic [39:0] ALPHA_FONT [26] = '{
    40'h7E1111117E, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C,
    40'h7F49494941, 40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F,
    40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906,
    40'h3E4151215E, 40'h7F09192946, 40'h4649494931, 40'h01017F0101,
    40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F, 40'h6314081463,
    40'h0708700807, 40'h6151494543
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic [6:0] cfg_wdata = '0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Model state.
  logic [7:0] char_store [ROWS*COLS];
  int         cursor_row;
  int         cursor_col;
  bit         cursor_on;
  phase_t     tx_phase;
  int         page_no;
  int         byte_pos;
  int         init_pos;
  int         x_off;

  out_item_t  panel_bytes_due [$];
  int         error_count = 0;
  int         quiet_cycles = 0;
  int         stall_left = 0;
  bit         steady;

  text_mode_oled_page_streamer_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < 100) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [7:0] font_column(input logic [7:0] ch, input int fc);
    logic [7:0]  up;
    logic [39:0] g;
    up = ch;
    if (ch >= "a" && ch <= "z") begin
      up = ch - ("a" - "A");
    end
    if (up >= "0" && up <= "9") begin
      g = NUM_FONT[up - "0"];
    end else if (up >= "A" && up <= "Z") begin
      g = ALPHA_FONT[up - "A"];
    end else begin
      case (up)
        ":":     g = 40'h0036360000;
        ".":     g = 40'h0060600000;
        "/":     g = 40'h2010080402;
        "%":     g = 40'h2313086462;
        "-":     g = 40'h0808080808;
        default: g = '0;
      endcase
    end
    return g[39 - 8*fc -: 8];
  endfunction

  function automatic logic [7:0] render_pixel_column(input int page, input int px);
    int d;
    int cell_idx;
    int fc;
    if (page >= ROWS || px < x_off) return 8'h00;
    d        = px - x_off;
    cell_idx = d / CELL_W;
    fc       = d % CELL_W;
    if (fc >= GLYPH_W || cell_idx >= COLS) return 8'h00;
    if (cell_idx*CELL_W + x_off + GLYPH_W > PANEL_W) return 8'h00;
    return font_column(char_store[page*COLS + cell_idx], fc);
  endfunction

  task automatic predict_panel_byte(input in_item_t r);
    out_item_t o;
    int        col;
    o = '0;
    if (tx_phase != PH_IDLE) begin
      if (r.cmd == CMD_TICK) begin
        if (tx_phase == PH_INIT) begin
          o.out_byte = POWER_UP_BYTES[init_pos];
          init_pos++;
          if (init_pos >= SEQ_LEN) begin
            init_pos = 0;
            tx_phase = PH_PAGES;
            page_no  = 0;
            byte_pos = 0;
          end
        end else begin
          if (byte_pos == 0) begin
            o.out_byte = PAGE_ADDR_CMD + 8'(page_no);
          end else if (byte_pos == 1) begin
            o.out_byte = COL_LOW_CMD;
          end else if (byte_pos == 2) begin
            o.out_byte = COL_HIGH_CMD;
          end else begin
            o.is_data       = 1'b1;
            o.out_byte      = render_pixel_column(page_no, byte_pos - HDR_LEN);
            o.end_of_stream = (byte_pos - HDR_LEN == PANEL_W - 1) &&
                              (page_no == PANEL_PAGES - 1);
          end
          byte_pos++;
          if (byte_pos >= HDR_LEN + PANEL_W) begin
            byte_pos = 0;
            if (page_no >= PANEL_PAGES - 1) begin
              tx_phase = PH_IDLE;
              page_no  = 0;
            end else begin
              page_no++;
            end
          end
        end
        panel_bytes_due.push_back(o);
      end
    end else begin
      case (r.cmd)
        CMD_SET_CURSOR: begin
          col = r.pixel_x / CELL_W;
          if (r.text_row >= ROWS || col >= COLS) begin
            cursor_on = 1'b0;
          end else begin
            cursor_row = r.text_row;
            cursor_col = col;
            cursor_on  = 1'b1;
          end
        end
        CMD_PUT_CHAR: begin
          if (cursor_on && cursor_row < ROWS && cursor_col < COLS) begin
            char_store[cursor_row*COLS + cursor_col] = r.char_code;
            cursor_col++;
            if (cursor_col >= COLS) cursor_on = 1'b0;
          end else begin
            cursor_on = 1'b0;
          end
        end
        CMD_CLEAR: begin
          foreach (char_store[i]) char_store[i] = SPACE_CHAR;
        end
        CMD_REFRESH: begin
          tx_phase = PH_PAGES;
          page_no  = 0;
          byte_pos = 0;
        end
        CMD_INIT: begin
          foreach (char_store[i]) char_store[i] = SPACE_CHAR;
          tx_phase = PH_INIT;
          init_pos = 0;
          page_no  = 0;
          byte_pos = 0;
        end
        default: ;
      endcase
    end
  endtask

  // Called and returns at a falling edge.
  task automatic send_req(input in_item_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_panel_byte(r);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (panel_bytes_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_x_offset(input logic [6:0] v);
    wait_drained();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    x_off = v;
  endtask

  function automatic in_item_t req(input logic [2:0] c, input logic [7:0] px,
                                   input logic [3:0] row, input logic [7:0] ch);
    in_item_t r;
    r.cmd       = c;
    r.pixel_x   = px;
    r.text_row  = row;
    r.char_code = ch;
    return r;
  endfunction

  function automatic in_item_t with_cmd(input logic [2:0] c);
    return req(c, 8'($urandom), 4'($urandom), 8'($urandom));
  endfunction

  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 99) < 65) return 8'($urandom_range(8'h20, 8'h7A));
    return 8'($urandom);
  endfunction

  function automatic in_item_t idle_noise();
    case ($urandom_range(0, 2))
      0:       return with_cmd(CMD_TICK);
      1:       return with_cmd(CMD_SPARE_6);
      default: return with_cmd(CMD_SPARE_7);
    endcase
  endfunction

  function automatic in_item_t busy_noise();
    in_item_t r;
    r = with_cmd(3'($urandom));
    if (r.cmd == CMD_TICK) r.cmd = CMD_SPARE_7;
    return r;
  endfunction

  task automatic fill_random_text(input int lines);
    repeat (lines) begin
      if ($urandom_range(0, 99) < 85) begin
        send_req(req(CMD_SET_CURSOR, 8'($urandom_range(0, 125)),
                     4'($urandom_range(0, ROWS - 1)), 8'($urandom)));
      end else begin
        send_req(with_cmd(CMD_SET_CURSOR));
      end
      repeat ($urandom_range(1, 24)) begin
        if ($urandom_range(0, 99) < 8) begin
          send_req(idle_noise());
        end else begin
          send_req(req(CMD_PUT_CHAR, 8'($urandom), 4'($urandom), pick_char()));
        end
      end
      if ($urandom_range(0, 99) < 3) send_req(with_cmd(CMD_CLEAR));
    end
  endtask

  task automatic run_transfer(input logic [2:0] start_cmd);
    send_req(with_cmd(start_cmd));
    while (tx_phase != PH_IDLE) begin
      if ($urandom_range(0, 199) == 0) steady = !steady;
      if ($urandom_range(0, 99) < 3) begin
        send_req(busy_noise());
      end else begin
        send_req(with_cmd(CMD_TICK));
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_init_sequence();
    write_x_offset(7'($urandom));
    run_transfer(CMD_INIT);
  endtask

  task automatic test_text_edits();
    send_req(req(CMD_TICK, 8'h00, 4'h0, 8'h00));
    send_req(req(CMD_SPARE_6, 8'hFF, 4'hF, 8'hFF));
    send_req(req(CMD_SPARE_7, 8'h00, 4'h0, 8'h00));
    send_req(req(CMD_PUT_CHAR, 8'h00, 4'h0, "Q"));
    send_req(req(CMD_SET_CURSOR, 8'd0, 4'd0, 8'h00));
    send_req(req(CMD_PUT_CHAR, 8'h00, 4'h0, "A"));
    send_req(req(CMD_PUT_CHAR, 8'h00, 4'h0, "z"));
    send_req(req(CMD_PUT_CHAR, 8'h00, 4'h0, 8'h00));
    send_req(req(CMD_PUT_CHAR, 8'h00, 4'h0, 8'hFF));
    send_req(req(CMD_PUT_CHAR, 8'h00, 4'h0, ":"));
    send_req(req(CMD_SET_CURSOR, 8'd6, 4'd1, 8'h00));
    send_req(req(CMD_PUT_CHAR, 8'h00, 4'h0, "-"));
    send_req(req(CMD_CLEAR, 8'h00, 4'h0, 8'h00));
    send_req(req(CMD_PUT_CHAR, 8'h00, 4'h0, "/"));
    send_req(req(CMD_PUT_CHAR, 8'h00, 4'h0, "."));
    send_req(req(CMD_SET_CURSOR, 8'd120, 4'd7, 8'h00));
    send_req(req(CMD_PUT_CHAR, 8'h00, 4'h0, "9"));
    send_req(req(CMD_PUT_CHAR, 8'h00, 4'h0, "X"));
    send_req(req(CMD_SET_CURSOR, 8'd126, 4'd2, 8'h00));
    send_req(req(CMD_PUT_CHAR, 8'h00, 4'h0, "W"));
    send_req(req(CMD_SET_CURSOR, 8'd12, 4'd8, 8'h00));
    send_req(req(CMD_PUT_CHAR, 8'h00, 4'h0, "W"));
    send_req(req(CMD_SET_CURSOR, 8'd255, 4'd15, 8'h00));
    send_req(req(CMD_SET_CURSOR, 8'd125, 4'd3, 8'h00));
    send_req(req(CMD_PUT_CHAR, 8'hFF, 4'hF, "%"));
  endtask

  task automatic test_clipped_refresh();
    write_x_offset(7'd4);
    fill_random_text(6);
    run_transfer(CMD_REFRESH);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (panel_bytes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", out_data.out_byte));
      end else begin
        want = panel_bytes_due.pop_front();
        if (out_data.is_data !== want.is_data) begin
          report_mismatch($sformatf("is_data %b, want %b",
                                    out_data.is_data, want.is_data));
        end
        if (out_data.out_byte !== want.out_byte) begin
          report_mismatch($sformatf("out_byte %02h, want %02h",
                                    out_data.out_byte, want.out_byte));
        end
        if (out_data.end_of_stream !== want.end_of_stream) begin
          report_mismatch($sformatf("end_of_stream %b, want %b",
                                    out_data.end_of_stream, want.end_of_stream));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (steady || $urandom_range(0, 1)) begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_stall  <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    foreach (char_store[i]) char_store[i] = SPACE_CHAR;
    cursor_row  = 0;
    cursor_col  = 0;
    cursor_on   = 1'b0;
    tx_phase    = PH_IDLE;
    page_no     = 0;
    byte_pos    = 0;
    init_pos    = 0;
    x_off       = 0;
    steady      = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_init_sequence();
    test_text_edits();
    test_clipped_refresh();

    wait_drained();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
sv/tmops_pkg.sv
sv/tmops_ctrl.sv
sv/tmops_datapath.sv
sv/text_mode_oled_page_streamer_unit.sv
dv/text_mode_oled_page_streamer_unit_test.sv
